@@ hw/rtl/kuf_pkg.sv @@
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared sizes for the union-find spanning-tree edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kuf_pkg;

    localparam int NUM_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(NUM_VERTICES);
    localparam int VTX_W        = 10;
    localparam int WEIGHT_W     = 48;
    localparam int TOTAL_W      = 58;

endpackage

`default_nettype wire

@@ hw/rtl/kruskal_union_find_edge_filter.sv @@
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Spanning-tree edge filter: union-find over a parent table held in RAM,
// with path compression and a saturating running total of kept weights.
//
//  channel  | handshake          | fields
//  ---------+--------------------+-----------------------------------------
//  edge in  | start, busy        | vertex_u, vertex_v, edge_weight
//  result   | done (one cycle)   | accepted, total_weight
//
// After reset each parent entry is loaded with its own index, busy stays high
// meanwhile. An in-range edge keeps busy high while it finds each endpoint's
// root, compresses its path and links the roots; every step is one RAM read
// through the single read port, compression writes ride alongside. An
// out-of-range edge is answered from idle with accepted low. done pulses for
// one cycle, for an in-range edge rising at the same edge at which busy falls;
// the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_filter
    import kuf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [VTX_W-1:0]    vertex_u,
    input  wire logic [VTX_W-1:0]    vertex_v,
    input  wire logic [WEIGHT_W-1:0] edge_weight,
    output logic                     done,
    output logic                     accepted,
    output logic [TOTAL_W-1:0]       total_weight
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_COMP,
        S_LINK
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_VERTICES - 1);

    state_t              state_reg,    state_next;
    logic [ADDR_W-1:0]   clr_reg,      clr_next;
    logic [ADDR_W-1:0]   u_reg,        u_next;
    logic [ADDR_W-1:0]   v_reg,        v_next;
    logic [WEIGHT_W-1:0] w_reg,        w_next;
    logic [ADDR_W-1:0]   root_reg,     root_next;
    logic [ADDR_W-1:0]   node_reg,     node_next;
    logic [ADDR_W-1:0]   ru_reg,       ru_next;
    logic                phase_v_reg,  phase_v_next;
    logic                done_reg,     done_next;
    logic                accepted_reg, accepted_next;
    logic [TOTAL_W-1:0]  total_reg,    total_next;
    logic                fwd_hit_reg,  fwd_hit_next;
    logic [ADDR_W-1:0]   fwd_data_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ADDR_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]   rd;

    logic                out_of_range;
    logic                phase_end;
    logic [ADDR_W-1:0]   start_vtx;
    logic [TOTAL_W:0]    sum;

    kuf_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_VERTICES)
    ) u_parent_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd           = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign out_of_range = (32'(vertex_u) >= NUM_VERTICES) || (32'(vertex_v) >= NUM_VERTICES);
    assign start_vtx    = phase_v_reg ? v_reg : u_reg;
    assign sum          = {1'b0, total_reg} + (TOTAL_W + 1)'(w_reg);
    assign fwd_hit_next = ram_we && (ram_waddr == ram_raddr);

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        w_next        = w_reg;
        root_next     = root_reg;
        node_next     = node_reg;
        ru_next       = ru_reg;
        phase_v_next  = phase_v_reg;
        done_next     = 1'b0;
        accepted_next = accepted_reg;
        total_next    = total_reg;
        ram_we        = 1'b0;
        ram_waddr     = node_reg;
        ram_wdata     = root_reg;
        ram_raddr     = root_reg;
        phase_end     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                u_next       = ADDR_W'(vertex_u);
                v_next       = ADDR_W'(vertex_v);
                ram_raddr    = ADDR_W'(vertex_u);
                if (start)
                begin
                    w_next = edge_weight;
                    if (out_of_range)
                    begin
                        done_next     = 1'b1;
                        accepted_next = 1'b0;
                    end
                    else
                    begin
                        root_next    = ADDR_W'(vertex_u);
                        phase_v_next = 1'b0;
                        state_next   = S_FIND;
                    end
                end
            end
            S_FIND:
            begin
                if (rd == root_reg)
                begin
                    if (start_vtx == root_reg)
                    begin
                        phase_end = 1'b1;
                    end
                    else
                    begin
                        node_next  = start_vtx;
                        ram_raddr  = start_vtx;
                        state_next = S_COMP;
                    end
                end
                else
                begin
                    root_next = rd;
                    ram_raddr = rd;
                end
            end
            S_COMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                ram_wdata = root_reg;
                if (rd == root_reg)
                begin
                    phase_end = 1'b1;
                end
                else
                begin
                    node_next = rd;
                    ram_raddr = rd;
                end
            end
            S_LINK:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (ru_reg != root_reg)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = root_reg;
                    ram_wdata     = ru_reg;
                    accepted_next = 1'b1;
                    total_next    = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                end
                else
                begin
                    accepted_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (phase_end)
        begin
            if (!phase_v_reg)
            begin
                ru_next      = root_reg;
                root_next    = v_reg;
                ram_raddr    = v_reg;
                phase_v_next = 1'b1;
                state_next   = S_FIND;
            end
            else
            begin
                state_next = S_LINK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            u_reg        <= '0;
            v_reg        <= '0;
            w_reg        <= '0;
            root_reg     <= '0;
            node_reg     <= '0;
            ru_reg       <= '0;
            phase_v_reg  <= 1'b0;
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
            total_reg    <= '0;
            fwd_hit_reg  <= 1'b0;
            fwd_data_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            u_reg        <= u_next;
            v_reg        <= v_next;
            w_reg        <= w_next;
            root_reg     <= root_next;
            node_reg     <= node_next;
            ru_reg       <= ru_next;
            phase_v_reg  <= phase_v_next;
            done_reg     <= done_next;
            accepted_reg <= accepted_next;
            total_reg    <= total_next;
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= ram_wdata;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign total_weight = total_reg;

endmodule

`default_nettype wire

@@ hw/rtl/kuf_ram.sv @@
// ----------------------------------------------------------------------------
// kuf_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/kuf_checker.sv @@
// ----------------------------------------------------------------------------
// kuf_checker
// Port-level checks for the spanning-tree edge filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_checker
    import kuf_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [VTX_W-1:0]    vertex_u,
    input wire logic [VTX_W-1:0]    vertex_v,
    input wire logic [WEIGHT_W-1:0] edge_weight,
    input wire logic                done,
    input wire logic                accepted,
    input wire logic [TOTAL_W-1:0]  total_weight
);

    logic [TOTAL_W-1:0] last_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else if (done)
        begin
            last_total_reg <= total_weight;
        end
    end

    // accepted transaction goes busy or answers at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither busy nor done");

    // a result follows an accepted transaction or busy work
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without a transaction");

    a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (total_weight >= last_total_reg))
        else $error("running total decreased");

    a_skip_holds_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accepted) |-> (total_weight == last_total_reg))
        else $error("skipped edge changed total");

    logic unused_ok;
    assign unused_ok = ^{vertex_u, vertex_v, edge_weight};

endmodule

bind kruskal_union_find_edge_filter kuf_checker u_kuf_checker (.*);

`default_nettype wire

@@ dv/kuf_span_checker.sv @@
// ----------------------------------------------------------------------------
// kuf_span_checker
// Watches the edge and result channels of the spanning-tree edge filter.
// Each accepted edge runs through a private union-find table with path
// compression and a saturating total. The outcome is queued and compared
// field by field with the next result strobe.
// ----------------------------------------------------------------------------
module kuf_span_checker
    import kuf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [VTX_W-1:0]    vertex_u,
    input  wire logic [VTX_W-1:0]    vertex_v,
    input  wire logic [WEIGHT_W-1:0] edge_weight,
    input  wire logic                done,
    input  wire logic                accepted,
    input  wire logic [TOTAL_W-1:0]  total_weight,
    output int                       errors,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               kept;
        logic [TOTAL_W-1:0] sum;
    } span_outcome_t;

    logic [VTX_W-1:0]   parent_of [NUM_VERTICES];
    logic [TOTAL_W-1:0] span_total;
    span_outcome_t      outcome_q [$];
    span_outcome_t      oldest;

    initial begin
        errors  = 0;
        pending = 0;
    end

    // Walk up to the root, then point every vertex on the path at it.
    function automatic logic [VTX_W-1:0] root_of(input logic [VTX_W-1:0] node);
        logic [VTX_W-1:0] root;
        logic [VTX_W-1:0] up;
        logic [VTX_W-1:0] cur;
        int               steps;
        root  = node;
        steps = 0;
        while (steps < NUM_VERTICES) begin
            up = parent_of[root];
            if (int'(up) >= NUM_VERTICES || up == root)
                break;
            root = up;
            steps++;
        end
        cur   = node;
        steps = 0;
        while (cur != root && steps < NUM_VERTICES) begin
            up             = parent_of[cur];
            parent_of[cur] = root;
            if (int'(up) >= NUM_VERTICES)
                break;
            cur = up;
            steps++;
        end
        return root;
    endfunction

    function automatic span_outcome_t take_edge(input logic [VTX_W-1:0]    u,
                                                input logic [VTX_W-1:0]    v,
                                                input logic [WEIGHT_W-1:0] w);
        span_outcome_t      res;
        logic [VTX_W-1:0]   ru;
        logic [VTX_W-1:0]   rv;
        logic [TOTAL_W:0]   grown;
        res.kept = 1'b0;
        if (int'(u) < NUM_VERTICES && int'(v) < NUM_VERTICES) begin
            ru = root_of(u);
            rv = root_of(v);
            if (ru != rv) begin
                parent_of[rv] = ru;
                grown         = span_total + w;
                span_total    = grown[TOTAL_W] ? '1 : grown[TOTAL_W-1:0];
                res.kept      = 1'b1;
            end
        end
        res.sum = span_total;
        return res;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_VERTICES; i++)
                parent_of[i] = i[VTX_W-1:0];
            span_total = '0;
            outcome_q.delete();
        end
        else begin
            if (start && !busy)
                outcome_q.insert(outcome_q.size(),
                                 take_edge(vertex_u, vertex_v, edge_weight));
            if (done) begin
                if (outcome_q.size() == 0) begin
                    errors++;
                    $error("result transaction with no edge outstanding");
                end
                else begin
                    oldest = outcome_q.pop_front();
                    if (accepted !== oldest.kept) begin
                        errors++;
                        $error("accepted: expected %0d, got %0d", oldest.kept, accepted);
                    end
                    if (total_weight !== oldest.sum) begin
                        errors++;
                        $error("total_weight: expected %0d, got %0d",
                               oldest.sum, total_weight);
                    end
                end
            end
        end
        pending <= outcome_q.size();
    end

endmodule

@@ dv/tb_kruskal_union_find_edge_filter.sv @@
// ----------------------------------------------------------------------------
// tb_kruskal_union_find_edge_filter
// Drives weighted edges into the union-find edge filter in bursts with random
// gaps: a directed set (self loops, extreme vertices and weights, a deep
// chain, out-of-order weight) followed by random chain-building, random,
// revisiting, extreme-vertex and self-loop edges over a mostly rising weight ramp.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_kruskal_union_find_edge_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import kuf_pkg::*;

    localparam int RANDOM_EDGES = 1730;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = '1;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [VTX_W-1:0]    vertex_u;
    logic [VTX_W-1:0]    vertex_v;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                done;
    logic                accepted;
    logic [TOTAL_W-1:0]  total_weight;
    int                  errors;
    int                  pending;
    int                  cycles = 0;
    int                  burst_left = 0;

    kruskal_union_find_edge_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .vertex_u     (vertex_u),
        .vertex_v     (vertex_v),
        .edge_weight  (edge_weight),
        .done         (done),
        .accepted     (accepted),
        .total_weight (total_weight)
    );

    kuf_span_checker span_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .vertex_u     (vertex_u),
        .vertex_v     (vertex_v),
        .edge_weight  (edge_weight),
        .done         (done),
        .accepted     (accepted),
        .total_weight (total_weight),
        .errors       (errors),
        .pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_edge(input logic [VTX_W-1:0]    u,
                             input logic [VTX_W-1:0]    v,
                             input logic [WEIGHT_W-1:0] w);
        start       <= 1'b1;
        vertex_u    <= u;
        vertex_v    <= v;
        edge_weight <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // End the current burst with a random gap, or keep streaming.
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial begin
        logic [63:0]         rnd;
        logic [WEIGHT_W-1:0] ramp;
        logic [WEIGHT_W-1:0] w;
        logic [WEIGHT_W:0]   next_w;
        logic [VTX_W-1:0]    u;
        logic [VTX_W-1:0]    v;
        logic [VTX_W-1:0]    chain_head;
        logic [VTX_W-1:0]    recent [16];
        int                  slot;
        int                  kind;

        rst_n       = 1'b0;
        start       = 1'b0;
        vertex_u    = '0;
        vertex_v    = '0;
        edge_weight = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_edge(10'd0, 10'd0, '0);                         pace();
        send_edge(10'd1023, 10'd1023, MAX_WEIGHT);           pace();
        send_edge(10'd0, 10'd1023, '0);                      pace();
        send_edge(10'd1023, 10'd0, 48'd1);                   pace();
        send_edge(10'd1, 10'd2, MAX_WEIGHT);                 pace();
        for (int k = 3; k <= 12; k++) begin
            send_edge(k[VTX_W-1:0], 10'(k - 1), 48'(k));
            pace();
        end
        send_edge(10'd512, 10'd2, 48'h8000_0000_0000);       pace();
        send_edge(10'd2, 10'd12, 48'h8000_0000_0000);        pace();
        send_edge(10'd341, 10'd682, 48'h5555_5555_5555);     pace();
        send_edge(10'd1023, 10'd512, 48'hAAAA_AAAA_AAAA);    pace();
        send_edge(10'd0, 10'd5, 48'hFFFF_FFFF_FFFF);         pace();
        send_edge(10'd100, 10'd200, 48'd7);                  pace();

        ramp       = 48'd16;
        chain_head = 10'd700;
        slot       = 0;
        for (int i = 0; i < 16; i++)
            recent[i] = 10'($urandom_range(0, NUM_VERTICES - 1));

        for (int n = 0; n < RANDOM_EDGES; n++) begin
            rnd = {$urandom, $urandom};
            if ($urandom_range(0, 4) == 0)
                w = rnd[WEIGHT_W-1:0];
            else begin
                rnd    = rnd >> $urandom_range(20, 63);
                next_w = ramp + rnd[WEIGHT_W-1:0];
                ramp   = next_w[WEIGHT_W] ? MAX_WEIGHT : next_w[WEIGHT_W-1:0];
                w      = ramp;
            end

            kind = $urandom_range(0, 19);
            u    = 10'($urandom_range(0, NUM_VERTICES - 1));
            v    = 10'($urandom_range(0, NUM_VERTICES - 1));
            if (kind <= 7) begin
                v          = chain_head;
                chain_head = u;
            end
            else if (kind >= 13 && kind <= 16) begin
                u = recent[$urandom_range(0, 15)];
                v = recent[$urandom_range(0, 15)];
            end
            else if (kind == 17)
                v = u;
            else if (kind >= 18) begin
                u = $urandom_range(0, 1) ? '1 : '0;
                if ($urandom_range(0, 1)) begin
                    v = u;
                    u = 10'($urandom_range(0, NUM_VERTICES - 1));
                end
            end

            recent[slot] = u;
            recent[(slot + 1) % 16] = v;
            slot = (slot + 2) % 16;

            send_edge(u, v, w);
            pace();
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ kruskal_union_find_edge_filter.f @@
hw/rtl/kuf_pkg.sv
hw/rtl/kuf_ram.sv
hw/rtl/kruskal_union_find_edge_filter.sv
hw/rtl/kuf_checker.sv
dv/kuf_span_checker.sv
dv/tb_kruskal_union_find_edge_filter.sv
